>>> hw/rtl/oca_pkg.sv
package oca_pkg;

    localparam int WORD_W = 12;
    localparam int MAG_W  = 11;
    localparam int SC_W   = 4;
    localparam int GRP_W  = 7;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    typedef logic [WORD_W-1:0] word_t;

    // instruction bits 11..5, memory reference group
    localparam logic [GRP_W-1:0] GRP_LDA = 7'o20;
    localparam logic [GRP_W-1:0] GRP_STA = 7'o21;
    localparam logic [GRP_W-1:0] GRP_ADA = 7'o22;
    localparam logic [GRP_W-1:0] GRP_ADM = 7'o23;
    localparam logic [GRP_W-1:0] GRP_LAM = 7'o24;
    localparam logic [GRP_W-1:0] GRP_MUL = 7'o25;
    localparam logic [GRP_W-1:0] GRP_LDH = 7'o26;
    localparam logic [GRP_W-1:0] GRP_STH = 7'o27;
    localparam logic [GRP_W-1:0] GRP_SHD = 7'o30;
    localparam logic [GRP_W-1:0] GRP_SAE = 7'o31;
    localparam logic [GRP_W-1:0] GRP_SRO = 7'o32;
    localparam logic [GRP_W-1:0] GRP_BCL = 7'o33;
    localparam logic [GRP_W-1:0] GRP_BSE = 7'o34;
    localparam logic [GRP_W-1:0] GRP_BCO = 7'o35;

    // instruction bits 11..5, operate groups
    localparam logic [GRP_W-1:0] GRP_ROL  = 7'o05;
    localparam logic [GRP_W-1:0] GRP_ROR  = 7'o06;
    localparam logic [GRP_W-1:0] GRP_SCR  = 7'o07;
    localparam logic [GRP_W-1:0] GRP_SKIP = 7'o11;

    // skip test selector, instruction bits 3..0 inside the skip group
    localparam logic [SC_W-1:0] SKT_AZE = 4'o10;
    localparam logic [SC_W-1:0] SKT_APO = 4'o11;
    localparam logic [SC_W-1:0] SKT_LZE = 4'o12;
    localparam logic [SC_W-1:0] SKT_FLO = 4'o14;
    localparam logic [SC_W-1:0] SKT_QLZ = 4'o15;
    localparam logic [SC_W-1:0] SKT_SKP = 4'o16;

    // full-word operate codes
    localparam word_t OP_QAC = 12'o0005;
    localparam word_t OP_CLR = 12'o0011;
    localparam word_t OP_NOP = 12'o0016;
    localparam word_t OP_COM = 12'o0017;

    localparam word_t WORD_ONES = 12'o7777;

    typedef struct packed {
        word_t acc;
        logic  link;
        word_t mq;
        logic  ovf;
    } oca_state_t;

    typedef struct packed {
        logic  skip;
        logic  write_enable;
        word_t write_data;
        logic  unsupported;
    } oca_flags_t;

endpackage

>>> hw/rtl/ones_complement_accumulator_alu.sv
// channel  dir  width  contents (lowest bit up)
// s_*      in   32     instruction[11:0], operand[23:12], half_select[24], zero fill
// m_*      out  48     acc_value, link_value, mq_value, overflow_value, skip,
//                      write_enable, write_data, unsupported, zero fill
//
// one transaction per cycle sustained while m_tready stays high; a result passes
// in turn through the input register, the execute logic with its
// 11x11 multiplier, and the result register that also loads acc/link/mq/overflow
// state is written back in the same cycle the result register loads, so the
// following instruction sees it straight away
// rst_n clears the state registers and both valid flags asynchronously
// a stalled m side holds the result; s_tready drops only when both registers are full
module ones_complement_accumulator_alu
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // instruction, operand, half_select
    input  logic [oca_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // acc_value, link_value, mq_value, overflow_value, skip, write_enable,
    // write_data, unsupported
    output logic [oca_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int W = oca_pkg::WORD_W;

    // input register
    logic           in_valid_reg;
    logic           in_valid_next;
    oca_pkg::word_t instr_reg;
    oca_pkg::word_t operand_reg;
    logic           half_reg;

    // architectural state
    oca_pkg::oca_state_t state_reg;
    oca_pkg::oca_state_t state_next;
    oca_pkg::oca_flags_t flags_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    oca_pkg::oca_state_t out_state_reg;
    oca_pkg::oca_flags_t out_flags_reg;

    logic s_take;
    logic advance;

    // the held instruction moves on when the result slot is free or emptying
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    oca_exec u_exec
    (
        .instruction (instr_reg),
        .operand     (operand_reg),
        .half_select (half_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .flags       (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            instr_reg   <= s_tdata[W-1:0];
            operand_reg <= s_tdata[2*W-1:W];
            half_reg    <= s_tdata[2*W];
        end
        if (advance)
        begin
            out_state_reg <= state_next;
            out_flags_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_flags_reg.unsupported,
                       out_flags_reg.write_data,
                       out_flags_reg.write_enable,
                       out_flags_reg.skip,
                       out_state_reg.ovf,
                       out_state_reg.mq,
                       out_state_reg.link,
                       out_state_reg.acc};

endmodule

>>> hw/rtl/oca_exec.sv
module oca_exec
(
    input  oca_pkg::word_t      instruction,
    input  oca_pkg::word_t      operand,
    input  logic                half_select,
    input  oca_pkg::oca_state_t cur,
    output oca_pkg::oca_state_t nxt,
    output oca_pkg::oca_flags_t flags
);

    localparam int W = oca_pkg::WORD_W;

    logic [oca_pkg::GRP_W-1:0] grp;
    logic [oca_pkg::SC_W-1:0]  sc;
    logic [oca_pkg::SC_W-1:0]  sc12;
    logic [oca_pkg::SC_W-1:0]  sc13;
    logic                      ibit;

    // ones' complement add with end-around carry
    logic [W:0]   ones_raw;
    logic [W:0]   ones_sum;
    logic         ones_ovf;
    // two's complement add with link
    logic [W:0]   lam_sum;
    logic         lam_ovf;

    // sign-magnitude multiply
    logic [oca_pkg::MAG_W-1:0]   mag_a;
    logic [oca_pkg::MAG_W-1:0]   mag_b;
    logic [2*oca_pkg::MAG_W-1:0] prod;
    logic [oca_pkg::MAG_W-1:0]   prod_sel;
    logic                        mul_sign;
    oca_pkg::word_t              mul_acc;

    logic [5:0]     half_word;

    // rotates
    logic [W:0]     v13;
    logic [2*W+1:0] rol13_wide;
    logic [2*W-1:0] rol12_wide;
    logic [2*W+1:0] ror13_wide;
    logic [2*W+1:0] ror13_mq_wide;
    logic [2*W-1:0] ror12_wide;
    logic [2*W-1:0] ror12_mq_wide;
    oca_pkg::word_t ror13_mq_in;
    oca_pkg::word_t ror12_mq_in;

    // arithmetic scale right
    logic           scr_big;
    oca_pkg::word_t scr_acc1;
    oca_pkg::word_t scr_mq1;
    logic           scr_lnk1;
    oca_pkg::word_t scr_acc2;
    logic [2*W-1:0] scr_mq_wide;
    logic [W:0]     scr_out_bit;
    logic           scr_lnk2;

    function automatic logic add_ovf(input oca_pkg::word_t a, input oca_pkg::word_t b,
                                     input logic [W:0] c);
        add_ovf = (a[W-1] & b[W-1] & ~c[W-1]) | (~a[W-1] & ~b[W-1] & c[W-1]);
    endfunction

    assign grp  = instruction[W-1:5];
    assign sc   = instruction[oca_pkg::SC_W-1:0];
    assign ibit = instruction[4];
    assign sc12 = (sc >= 4'd12) ? sc - 4'd12 : sc;
    assign sc13 = (sc >= 4'd13) ? sc - 4'd13 : sc;

    assign ones_raw = {1'b0, cur.acc} + {1'b0, operand};
    assign ones_sum = ones_raw + {{W{1'b0}}, ones_raw[W]};
    assign ones_ovf = add_ovf(cur.acc, operand, ones_sum);

    assign lam_sum = {1'b0, cur.acc} + {1'b0, operand} + {{W{1'b0}}, cur.link};
    assign lam_ovf = add_ovf(cur.acc, operand, lam_sum);

    assign mag_a    = cur.acc[W-1] ? ~cur.acc[oca_pkg::MAG_W-1:0] : cur.acc[oca_pkg::MAG_W-1:0];
    assign mag_b    = operand[W-1] ? ~operand[oca_pkg::MAG_W-1:0] : operand[oca_pkg::MAG_W-1:0];
    assign prod     = mag_a * mag_b;
    assign mul_sign = cur.acc[W-1] ^ operand[W-1];
    assign prod_sel = half_select ? prod[2*oca_pkg::MAG_W-1:oca_pkg::MAG_W]
                                  : prod[oca_pkg::MAG_W-1:0];
    assign mul_acc  = mul_sign ? ~{1'b0, prod_sel} : {1'b0, prod_sel};

    assign half_word = half_select ? operand[5:0] : operand[W-1:6];

    assign v13         = {cur.link, cur.acc};
    assign rol13_wide  = {v13, v13} << sc13;
    assign rol12_wide  = {cur.acc, cur.acc} << sc12;
    assign ror13_mq_in = (sc >= 4'd13) ? v13[W:1] : cur.mq;
    assign ror12_mq_in = (sc >= 4'd12) ? cur.acc : cur.mq;
    // the bit between link-acc and mq stays empty on a 13-bit ring
    assign ror13_mq_wide = {v13, 1'b0, ror13_mq_in} >> sc13;
    assign ror13_wide    = {v13, v13} >> sc13;
    assign ror12_mq_wide = {cur.acc, ror12_mq_in} >> sc12;
    assign ror12_wide    = {cur.acc, cur.acc} >> sc12;

    assign scr_big     = sc >= 4'd12;
    assign scr_acc1    = scr_big ? {W{cur.acc[W-1]}} : cur.acc;
    assign scr_mq1     = scr_big ? cur.acc : cur.mq;
    assign scr_lnk1    = (scr_big && ibit) ? cur.acc[W-1] : cur.link;
    assign scr_acc2    = oca_pkg::word_t'($signed(scr_acc1) >>> sc12);
    assign scr_mq_wide = {scr_acc1, scr_mq1} >> sc12;
    assign scr_out_bit = {scr_acc1, 1'b0} >> sc12;
    assign scr_lnk2    = (ibit && (sc12 != '0)) ? scr_out_bit[0] : scr_lnk1;

    always_comb
    begin
        nxt   = cur;
        flags = '0;
        priority if (instruction[W-1:W-2] != 2'b00)
        begin
            flags.unsupported = 1'b1;
        end
        else if (instruction[W-3])
        begin
            unique case (grp)
                oca_pkg::GRP_LDA: nxt.acc = operand;
                oca_pkg::GRP_STA:
                begin
                    flags.write_enable = 1'b1;
                    flags.write_data   = cur.acc;
                end
                oca_pkg::GRP_ADA:
                begin
                    nxt.acc = ones_sum[W-1:0];
                    nxt.ovf = ones_ovf;
                end
                oca_pkg::GRP_ADM:
                begin
                    nxt.acc            = ones_sum[W-1:0];
                    nxt.ovf            = ones_ovf;
                    flags.write_enable = 1'b1;
                    flags.write_data   = ones_sum[W-1:0];
                end
                oca_pkg::GRP_LAM:
                begin
                    nxt.acc  = lam_sum[W-1:0];
                    nxt.link = lam_sum[W];
                    nxt.ovf  = lam_ovf;
                end
                oca_pkg::GRP_MUL:
                begin
                    nxt.acc  = mul_acc;
                    nxt.link = mul_sign;
                    nxt.mq   = {prod[oca_pkg::MAG_W-1:0], 1'b0};
                end
                oca_pkg::GRP_LDH: nxt.acc = {6'd0, half_word};
                oca_pkg::GRP_STH:
                begin
                    flags.write_enable = 1'b1;
                    flags.write_data   = half_select ? {operand[W-1:6], cur.acc[5:0]}
                                                     : {cur.acc[5:0], operand[5:0]};
                end
                oca_pkg::GRP_SHD: flags.skip = half_word != cur.acc[5:0];
                oca_pkg::GRP_SAE: flags.skip = cur.acc == operand;
                oca_pkg::GRP_SRO:
                begin
                    flags.skip         = ~operand[0];
                    flags.write_enable = 1'b1;
                    flags.write_data   = {operand[0], operand[W-1:1]};
                end
                oca_pkg::GRP_BCL: nxt.acc = cur.acc & ~operand;
                oca_pkg::GRP_BSE: nxt.acc = cur.acc | operand;
                oca_pkg::GRP_BCO: nxt.acc = cur.acc ^ operand;
                default:          flags.unsupported = 1'b1;
            endcase
        end
        else if (grp == oca_pkg::GRP_ROL)
        begin
            if (ibit)
            begin
                nxt.acc  = rol13_wide[2*W:W+1];
                nxt.link = rol13_wide[2*W+1];
            end
            else
            begin
                nxt.acc = rol12_wide[2*W-1:W];
            end
        end
        else if (grp == oca_pkg::GRP_ROR)
        begin
            if (ibit)
            begin
                nxt.acc  = ror13_wide[W-1:0];
                nxt.link = ror13_wide[W];
                nxt.mq   = ror13_mq_wide[W-1:0];
            end
            else
            begin
                nxt.acc = ror12_wide[W-1:0];
                nxt.mq  = ror12_mq_wide[W-1:0];
            end
        end
        else if (grp == oca_pkg::GRP_SCR)
        begin
            nxt.acc  = scr_acc2;
            nxt.mq   = scr_mq_wide[W-1:0];
            nxt.link = scr_lnk2;
        end
        else if (grp == oca_pkg::GRP_SKIP)
        begin
            unique case (sc)
                oca_pkg::SKT_APO: flags.skip = ibit ^ ~cur.acc[W-1];
                oca_pkg::SKT_AZE: flags.skip = ibit ^ ((cur.acc == '0)
                                                       || (cur.acc == oca_pkg::WORD_ONES));
                oca_pkg::SKT_LZE: flags.skip = ibit ^ ~cur.link;
                oca_pkg::SKT_QLZ: flags.skip = ibit ^ ~cur.mq[0];
                oca_pkg::SKT_FLO: flags.skip = ibit ^ cur.ovf;
                oca_pkg::SKT_SKP: flags.skip = ~ibit;
                default:          flags.unsupported = 1'b1;
            endcase
        end
        else
        begin
            unique case (instruction)
                oca_pkg::OP_CLR:
                begin
                    nxt.acc  = '0;
                    nxt.link = 1'b0;
                    nxt.mq   = '0;
                end
                oca_pkg::OP_COM: nxt.acc = ~cur.acc;
                oca_pkg::OP_NOP: nxt.acc = cur.acc;
                oca_pkg::OP_QAC: nxt.acc = {1'b0, cur.mq[W-1:1]};
                default:         flags.unsupported = 1'b1;
            endcase
        end
        if (flags.unsupported)
        begin
            nxt   = cur;
            flags = '0;
            flags.unsupported = 1'b1;
        end
    end

endmodule

>>> hw/rtl/oca_checker.sv
module oca_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [oca_pkg::M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // back-pressure on s only when the result side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without m stall");

    // unsupported leaves skip, store and store data clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> m_tdata[39:26] == 14'd0)
        else $error("unsupported result with side effects");

    // no store means zero store data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[27] |-> m_tdata[39:28] == 12'd0)
        else $error("write_data set without write_enable");

endmodule

bind ones_complement_accumulator_alu oca_checker u_oca_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
